// ===== hdl/biq_pkg.sv =====
// ---------------------------------------------------------------------------
// biq_pkg: shared types, constants and microcode for the biquad filter
// Holds the datapath widths, the control word layout and the step program.
// ---------------------------------------------------------------------------
package biq_pkg;

    localparam int MAX_CHANNELS = 8;
    localparam int CH_IDX_W     = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    localparam int SAMPLE_W = 24;
    localparam int CH_W     = 3;
    localparam int COEF_W   = 24;
    localparam int NUM_COEF = 5;
    localparam int CFG_IDX_W = 3;
    localparam int PROD_W   = 48;
    localparam int DELAY_W  = 40;
    localparam int ACC_W    = 54;

    typedef logic signed [COEF_W-1:0] t_coef;
    typedef logic [NUM_COEF-1:0][COEF_W-1:0] t_coef_bank;

    // Coefficient selector, equal to the register index of the coefficient
    typedef enum logic [CFG_IDX_W-1:0] {
        COEF_B0 = 3'd0,
        COEF_B1 = 3'd1,
        COEF_B2 = 3'd2,
        COEF_A1 = 3'd3,
        COEF_A2 = 3'd4
    } t_coef_sel;

    localparam logic [COEF_W-1:0] COEF_B0_RST = 24'd1048576;

    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_LOAD_D1,
        ACC_ADD_P,
        ACC_SUB_P,
        ACC_LOAD_P
    } t_acc_op;

    typedef enum logic [1:0] {
        SEQ_NEXT,
        SEQ_WAIT_IN,
        SEQ_EMIT
    } t_seq;

    typedef enum logic [3:0] {
        STEP_WAIT    = 4'd0,
        STEP_MUL_B0  = 4'd1,
        STEP_ACC_B0  = 4'd2,
        STEP_ROUND_Y = 4'd3,
        STEP_MUL_A1  = 4'd4,
        STEP_SUB_A1  = 4'd5,
        STEP_DELAY1  = 4'd6,
        STEP_SUB_A2  = 4'd7,
        STEP_EMIT    = 4'd8
    } t_step;

    typedef struct packed {
        t_seq      seq;
        t_step     jmp;
        t_coef_sel coef;
        logic      mul_y;
        t_acc_op   acc_op;
        logic      y_ld;
        logic      d1_wr;
        logic      d2_wr;
    } t_uop;

    localparam t_uop UOP_IDLE = '{
        seq: SEQ_NEXT, jmp: STEP_WAIT, coef: COEF_B0, mul_y: 1'b0,
        acc_op: ACC_HOLD, y_ld: 1'b0, d1_wr: 1'b0, d2_wr: 1'b0
    };

    // Step program. The multiplier output is registered in the product register, so
    // a step that selects the operands does not itself see their product.
    function automatic t_uop uop_rom(input t_step s);
        t_uop u;
        u = UOP_IDLE;
        case (s)
            STEP_WAIT: begin
                u.seq = SEQ_WAIT_IN;
                u.jmp = STEP_EMIT;
            end
            STEP_MUL_B0: begin
                u.coef   = COEF_B0;
                u.acc_op = ACC_LOAD_D1;
            end
            STEP_ACC_B0: begin
                u.coef   = COEF_B1;
                u.acc_op = ACC_ADD_P;
            end
            STEP_ROUND_Y: begin
                u.y_ld   = 1'b1;
                u.acc_op = ACC_LOAD_P;
            end
            STEP_MUL_A1: begin
                u.coef  = COEF_A1;
                u.mul_y = 1'b1;
            end
            STEP_SUB_A1: begin
                u.coef   = COEF_B2;
                u.acc_op = ACC_SUB_P;
            end
            STEP_DELAY1: begin
                u.d1_wr  = 1'b1;
                u.acc_op = ACC_LOAD_P;
                u.coef   = COEF_A2;
                u.mul_y  = 1'b1;
            end
            STEP_SUB_A2: begin
                u.acc_op = ACC_SUB_P;
            end
            STEP_EMIT: begin
                u.seq   = SEQ_EMIT;
                u.jmp   = STEP_WAIT;
                u.d2_wr = 1'b1;
            end
            default: begin
                u.seq = SEQ_EMIT;
                u.jmp = STEP_WAIT;
            end
        endcase
        return u;
    endfunction

endpackage

// ===== hdl/biq_datapath.sv =====
// ---------------------------------------------------------------------------
// biq_datapath: shared multiplier, accumulator and per-channel delay state
// Executes one control word per cycle; keeps two saturating delays per channel.
// ---------------------------------------------------------------------------
module biq_datapath (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_ld,
    input  logic signed [biq_pkg::SAMPLE_W-1:0]    i_sample,
    input  logic [biq_pkg::CH_W-1:0]               i_ch,
    input  logic                                   i_ch_ok,
    input  biq_pkg::t_coef_bank                    i_coefs,
    input  biq_pkg::t_uop                          i_uop,
    output logic signed [biq_pkg::SAMPLE_W-1:0]    o_y,
    output logic                                   o_clip
);
    import biq_pkg::*;

    localparam int YR_W  = ACC_W - 20;
    localparam int DS_W  = ACC_W - 12 + 1;

    logic signed [SAMPLE_W-1:0] r_x;
    logic signed [SAMPLE_W-1:0] r_y;
    logic                       r_clip;
    logic [CH_W-1:0]            r_ch;
    logic                       r_ch_ok;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [ACC_W-1:0]    n_acc;
    logic signed [DELAY_W-1:0]  r_d1 [MAX_CHANNELS];
    logic signed [DELAY_W-1:0]  r_d2 [MAX_CHANNELS];

    logic [CH_IDX_W-1:0]        w_idx;
    logic signed [DELAY_W-1:0]  w_d1;
    logic signed [DELAY_W-1:0]  w_d2;
    logic signed [COEF_W-1:0]   w_coef;
    logic signed [SAMPLE_W-1:0] w_op;
    logic signed [ACC_W-1:0]    w_prod_ext;
    logic signed [ACC_W-1:0]    w_round;
    logic signed [YR_W-1:0]     w_yr;
    logic [YR_W-SAMPLE_W:0]     w_yr_hi;
    logic                       w_y_fits;
    logic signed [SAMPLE_W-1:0] w_y_sat;
    logic signed [DS_W-1:0]     w_d1_sum;
    logic signed [DS_W-1:0]     w_d2_sum;
    logic signed [DELAY_W-1:0]  w_d1_new;
    logic signed [DELAY_W-1:0]  w_d2_new;

    function automatic logic signed [DELAY_W-1:0] sat_delay(
        input logic signed [DS_W-1:0] v
    );
        logic [DS_W-DELAY_W:0] hi;
        hi = v[DS_W-1:DELAY_W-1];
        if ((&hi) || !(|hi)) begin
            return v[DELAY_W-1:0];
        end else if (v[DS_W-1]) begin
            return {1'b1, {(DELAY_W-1){1'b0}}};
        end else begin
            return {1'b0, {(DELAY_W-1){1'b1}}};
        end
    endfunction

    assign w_idx = CH_IDX_W'(r_ch);
    assign w_d1  = r_d1[w_idx];
    assign w_d2  = r_d2[w_idx];

    always_comb begin
        case (i_uop.coef)
            COEF_B0: w_coef = i_coefs[COEF_B0];
            COEF_B1: w_coef = i_coefs[COEF_B1];
            COEF_B2: w_coef = i_coefs[COEF_B2];
            COEF_A1: w_coef = i_coefs[COEF_A1];
            COEF_A2: w_coef = i_coefs[COEF_A2];
            default: w_coef = '0;
        endcase
    end

    assign w_op       = i_uop.mul_y ? r_y : r_x;
    assign w_prod_ext = {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};

    // Round half up to Q1.23, then clamp to the sample range
    assign w_round  = r_acc + ACC_W'(524288);
    assign w_yr     = w_round[ACC_W-1:20];
    assign w_yr_hi  = w_yr[YR_W-1:SAMPLE_W-1];
    assign w_y_fits = (&w_yr_hi) || !(|w_yr_hi);
    assign w_y_sat  = w_y_fits ? w_yr[SAMPLE_W-1:0]
                    : (w_yr[YR_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}}
                                    : {1'b0, {(SAMPLE_W-1){1'b1}}});

    assign w_d1_sum = {r_acc[ACC_W-1], r_acc[ACC_W-1:12]}
                    + {{(DS_W-DELAY_W){w_d2[DELAY_W-1]}}, w_d2};
    assign w_d2_sum = {r_acc[ACC_W-1], r_acc[ACC_W-1:12]};
    assign w_d1_new = sat_delay(w_d1_sum);
    assign w_d2_new = sat_delay(w_d2_sum);

    always_comb begin
        case (i_uop.acc_op)
            ACC_HOLD:    n_acc = r_acc;
            ACC_LOAD_D1: n_acc = {{(ACC_W-DELAY_W-12){w_d1[DELAY_W-1]}}, w_d1, 12'b0};
            ACC_ADD_P:   n_acc = r_acc + w_prod_ext;
            ACC_SUB_P:   n_acc = r_acc - w_prod_ext;
            ACC_LOAD_P:  n_acc = w_prod_ext;
            default:     n_acc = r_acc;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_coef * w_op;
        r_acc  <= n_acc;
        if (i_ld) begin
            r_x     <= i_sample;
            r_y     <= i_sample;
            r_clip  <= 1'b0;
            r_ch    <= i_ch;
            r_ch_ok <= i_ch_ok;
        end else if (i_uop.y_ld) begin
            r_y    <= w_y_sat;
            r_clip <= !w_y_fits;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_CHANNELS; i++) begin
                r_d1[i] <= '0;
                r_d2[i] <= '0;
            end
        end else begin
            if (i_uop.d1_wr && r_ch_ok) begin
                r_d1[w_idx] <= w_d1_new;
            end
            if (i_uop.d2_wr && r_ch_ok) begin
                r_d2[w_idx] <= w_d2_new;
            end
        end
    end

    assign o_y    = r_y;
    assign o_clip = r_clip;

endmodule

// ===== hdl/multichannel_biquad_filter.sv =====
// ---------------------------------------------------------------------------
// multichannel_biquad_filter: eight-channel biquad IIR, transposed form II
// Microcoded sequencer over one 24x24 multiplier with a 54-bit accumulator.
// ---------------------------------------------------------------------------
// A beat runs through the nine-step program on the single shared multiplier;
// a channel outside the delay table jumps to the emit step and passes the
// sample through. The next beat is not taken until the program is through
// with the last one; the next beat is taken while a result waits.
// Reset (synchronous, active low): clears all channel delays, loads b0 = 1.0
// and the other coefficients with zero, and empties the output register.
// ---------------------------------------------------------------------------
module multichannel_biquad_filter (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [biq_pkg::SAMPLE_W-1:0]      s_axis_tdata,  // [23:0] sample_in
    input  logic [biq_pkg::CH_W-1:0]          s_axis_tuser,  // [2:0] channel
    input  logic                              s_axis_tlast,  // last_in
    // output stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [biq_pkg::SAMPLE_W-1:0]      m_axis_tdata,  // [23:0] sample_out
    output logic [biq_pkg::CH_W:0]            m_axis_tuser,  // [2:0] channel_out, [3] clipped
    output logic                              m_axis_tlast,  // last_out
    // coefficient write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [biq_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [biq_pkg::COEF_W-1:0]        i_cfg_data
);
    import biq_pkg::*;

    t_step      r_step;
    t_step      n_step;
    t_uop       w_uop;
    t_coef_bank r_coefs;

    logic       w_in_beat;
    logic       w_ch_ok;
    logic       w_out_free;
    logic       w_emit;

    logic [CH_W-1:0]            r_ch;
    logic                       r_last;
    logic                       r_out_valid;
    logic [SAMPLE_W-1:0]        r_out_data;
    logic [CH_W:0]              r_out_user;
    logic                       r_out_last;
    logic signed [SAMPLE_W-1:0] w_y;
    logic                       w_clip;

    // The control word for the current step comes straight from the program
    assign w_uop = uop_rom(r_step);

    // Hold off input beats while reset is applied
    assign s_axis_tready = i_rst_n && (w_uop.seq == SEQ_WAIT_IN);
    assign w_in_beat     = s_axis_tvalid && s_axis_tready;
    assign w_ch_ok       = (32'(s_axis_tuser) < MAX_CHANNELS);

    // The output register may take a new result when empty or being drained
    assign w_out_free = !r_out_valid || m_axis_tready;
    assign w_emit     = (w_uop.seq == SEQ_EMIT) && w_out_free;

    // Sequencer: advance, wait for a beat, or wait for room at the output.
    // A channel outside the table jumps straight to the emit step.
    always_comb begin
        n_step = r_step;
        case (w_uop.seq)
            SEQ_NEXT: begin
                n_step = t_step'(r_step + 4'd1);
            end
            SEQ_WAIT_IN: begin
                if (w_in_beat) begin
                    n_step = w_ch_ok ? t_step'(r_step + 4'd1) : w_uop.jmp;
                end
            end
            SEQ_EMIT: begin
                if (w_out_free) begin
                    n_step = w_uop.jmp;
                end
            end
            default: begin
                n_step = STEP_WAIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_WAIT;
        end else begin
            r_step <= n_step;
        end
    end

    // Coefficient registers; writes to an index past the list are dropped
    assign o_cfg_ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs <= {{((NUM_COEF-1)*COEF_W){1'b0}}, COEF_B0_RST};
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                COEF_B0: r_coefs[COEF_B0] <= i_cfg_data;
                COEF_B1: r_coefs[COEF_B1] <= i_cfg_data;
                COEF_B2: r_coefs[COEF_B2] <= i_cfg_data;
                COEF_A1: r_coefs[COEF_A1] <= i_cfg_data;
                COEF_A2: r_coefs[COEF_A2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sideband of the beat in flight
    always_ff @(posedge i_clk) begin
        if (w_in_beat) begin
            r_ch   <= s_axis_tuser;
            r_last <= s_axis_tlast;
        end
    end

    biq_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ld     (w_in_beat),
        .i_sample (s_axis_tdata),
        .i_ch     (s_axis_tuser),
        .i_ch_ok  (w_ch_ok),
        .i_coefs  (r_coefs),
        .i_uop    (w_uop),
        .o_y      (w_y),
        .o_clip   (w_clip)
    );

    // Output register: hold a result until the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_data <= w_y;
            r_out_user <= {w_clip, r_ch};
            r_out_last <= r_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;
    assign m_axis_tlast  = r_out_last;

endmodule

// ===== tb/multichannel_biquad_filter_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// multichannel_biquad_filter_tb: self-checking bench for the biquad filter
// Drives sample beats on random channels under several coefficient sets,
// predicts every filtered sample in fixed point and checks the output stream.
// ---------------------------------------------------------------------------
module multichannel_biquad_filter_tb;
    import biq_pkg::*;

    // Saturation limits of the output sample and of the delay registers
    localparam longint SAMPLE_HI = (64'sd1 <<< (SAMPLE_W - 1)) - 1;
    localparam longint SAMPLE_LO = -(64'sd1 <<< (SAMPLE_W - 1));
    localparam longint DLY_HI    = (64'sd1 <<< (DELAY_W - 1)) - 1;
    localparam longint DLY_LO    = -(64'sd1 <<< (DELAY_W - 1));

    localparam int BEATS_PER_SET = 180;   // random beats per coefficient set
    localparam int SETTLE_CYCLES = 12;    // extra wait once every result is back

    typedef struct {
        logic [SAMPLE_W-1:0] sample;
        logic [CH_W-1:0]     ch;
        logic                last;
        logic                clip;
    } t_filt_beat;

    // Shadow filter: own copy of the coefficients and per-channel delays,
    // plus the queue of filtered samples still owed by the block.
    class t_biquad_shadow;
        longint b0, b1, b2, a1, a2;
        longint d1_mem [MAX_CHANNELS];
        longint d2_mem [MAX_CHANNELS];
        t_filt_beat owed_q [$];
        int mismatches;
        int outputs_seen;
        int clipped_seen;

        function new();
            b0 = longint'($signed(COEF_B0_RST));
            b1 = 0;
            b2 = 0;
            a1 = 0;
            a2 = 0;
        endfunction

        static function longint clamp(longint v, longint lo, longint hi);
            if (v > hi) return hi;
            if (v < lo) return lo;
            return v;
        endfunction

        function void load_coef(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] val);
            longint c;
            c = longint'($signed(val));
            case (idx)
                COEF_B0: b0 = c;
                COEF_B1: b1 = c;
                COEF_B2: b2 = c;
                COEF_A1: a1 = c;
                COEF_A2: a2 = c;
                default: ;   // drop writes past the coefficient bank
            endcase
        endfunction

        // Filter one accepted sample and queue the result it must produce
        function void note_sample(logic [SAMPLE_W-1:0] s, logic [CH_W-1:0] ch, logic last);
            longint x, acc, y_raw, y;
            t_filt_beat e;
            x      = longint'($signed(s));
            e.ch   = ch;
            e.last = last;
            e.sample = s;
            e.clip = 1'b0;
            if (ch < MAX_CHANNELS) begin
                acc   = b0 * x + (d1_mem[ch] <<< 12);
                y_raw = (acc + (64'sd1 <<< 19)) >>> 20;
                y     = clamp(y_raw, SAMPLE_LO, SAMPLE_HI);
                e.clip   = (y != y_raw);
                e.sample = y[SAMPLE_W-1:0];
                d1_mem[ch] = clamp(((b1 * x - a1 * y) >>> 12) + d2_mem[ch], DLY_LO, DLY_HI);
                d2_mem[ch] = clamp((b2 * x - a2 * y) >>> 12, DLY_LO, DLY_HI);
            end
            owed_q.push_back(e);
        endfunction

        task report(string what);
            $display("MISMATCH at %0t: %s", $time, what);
            mismatches++;
        endtask

        task check_beat(logic [SAMPLE_W-1:0] d, logic [CH_W:0] u, logic l);
            t_filt_beat e;
            outputs_seen++;
            if (u[CH_W]) clipped_seen++;
            if (owed_q.size() == 0) begin
                report($sformatf("output beat %h with no sample outstanding", d));
                return;
            end
            e = owed_q.pop_front();
            if (d !== e.sample)
                report($sformatf("sample_out got %h want %h (ch %0d)", d, e.sample, e.ch));
            if (u[CH_W-1:0] !== e.ch)
                report($sformatf("channel_out got %0d want %0d", u[CH_W-1:0], e.ch));
            if (u[CH_W] !== e.clip)
                report($sformatf("clipped got %b want %b (ch %0d)", u[CH_W], e.clip, e.ch));
            if (l !== e.last)
                report($sformatf("last_out got %b want %b (ch %0d)", l, e.last, e.ch));
        endtask
    endclass

    logic                i_clk;
    logic                i_rst_n       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [SAMPLE_W-1:0] s_axis_tdata  = '0;   // [23:0] sample_in
    logic [CH_W-1:0]     s_axis_tuser  = '0;   // [2:0] channel
    logic                s_axis_tlast  = 1'b0; // last_in
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [SAMPLE_W-1:0] m_axis_tdata;         // [23:0] sample_out
    logic [CH_W:0]       m_axis_tuser;         // [2:0] channel_out, [3] clipped
    logic                m_axis_tlast;         // last_out
    logic                i_cfg_valid   = 1'b0;
    logic                o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index  = '0;
    logic [COEF_W-1:0]   i_cfg_data    = '0;

    t_biquad_shadow sb = new();

    int tx_idle_pct = 0;   // chance in percent that a beat is preceded by a gap
    int rx_idle_pct = 0;   // chance in percent that the sink holds ready low
    int rx_hold     = 0;   // cycles left in a forced long sink stall
    int beats_sent  = 0;
    int cfg_writes  = 0;
    int coef_sets   = 0;

    multichannel_biquad_filter uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Sink side: a forced hold wins over the random stalls. The hold is
    // counted here so the sender keeps offering beats while the block fills.
    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            rx_hold = rx_hold - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Check every output beat against the oldest outstanding sample
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_beat(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end

    // Offer one sample beat, optionally after a random gap, and hold it until
    // the block takes it. Valid stays high into the next beat when no gap is drawn.
    task automatic send_sample(logic [SAMPLE_W-1:0] s, logic [CH_W-1:0] ch, logic last);
        int gap;
        gap = ($urandom_range(99) < tx_idle_pct) ? $urandom_range(1, 12) : 0;
        repeat (gap) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= s;
        s_axis_tuser  <= ch;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_sample(s, ch, last);
        beats_sent++;
    endtask

    // Drop valid, wait for every owed result, then let the pipeline drain
    task automatic quiesce();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (sb.owed_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.load_coef(idx, val);
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Load a full coefficient set while the block is idle. A write to an
    // unused index is slipped in to make sure it leaves the bank alone.
    task automatic load_filter(longint nb0, longint nb1, longint nb2,
                               longint na1, longint na2);
        quiesce();
        write_reg(COEF_B0, nb0[COEF_W-1:0]);
        write_reg(COEF_B1, nb1[COEF_W-1:0]);
        write_reg(CFG_IDX_W'($urandom_range(NUM_COEF, 2**CFG_IDX_W - 1)),
                  COEF_W'($urandom));
        write_reg(COEF_B2, nb2[COEF_W-1:0]);
        write_reg(COEF_A1, na1[COEF_W-1:0]);
        write_reg(COEF_A2, na2[COEF_W-1:0]);
        coef_sets++;
    endtask

    function automatic longint rand_coef(bit narrow);
        if (narrow)
            return longint'($urandom_range(0, 2**21)) - 2**20;
        return longint'($signed(COEF_W'($urandom)));
    endfunction

    // Mostly full-range samples, with a share of full-scale and near-zero values
    function automatic logic [SAMPLE_W-1:0] rand_sample();
        logic [SAMPLE_W-1:0] r;
        r = SAMPLE_W'($urandom);
        case ($urandom_range(9))
            0: r = {1'b0, {(SAMPLE_W-1){1'b1}}};
            1: r = {1'b1, {(SAMPLE_W-1){1'b0}}};
            2, 3: r = {{(SAMPLE_W-10){r[SAMPLE_W-1]}}, r[9:0]};
            default: ;
        endcase
        return r;
    endfunction

    initial begin
        logic [CH_W-1:0] cur_ch;
        logic            last;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset coefficients give unity gain, so extremes and bit
        // patterns must pass straight through on every channel.
        send_sample(24'h7FFFFF, 0, 1'b0);
        send_sample(24'h800000, 1, 1'b0);
        send_sample(24'h000000, 2, 1'b0);
        send_sample(24'hFFFFFF, 3, 1'b0);
        send_sample(24'h000001, 4, 1'b0);
        send_sample(24'h555555, 5, 1'b0);
        send_sample(24'hAAAAAA, 6, 1'b0);
        send_sample(24'h400000, 7, 1'b1);

        // Largest coefficients: output clips both ways, feedback uses the
        // clipped value and the delays build up on one channel.
        load_filter(SAMPLE_HI, SAMPLE_HI, SAMPLE_HI, SAMPLE_HI, SAMPLE_HI);
        send_sample(24'h7FFFFF, 0, 1'b0);
        send_sample(24'h800000, 0, 1'b0);
        send_sample(24'h7FFFFF, 0, 1'b0);
        send_sample(24'h000000, 0, 1'b0);
        send_sample(24'h000000, 0, 1'b1);
        send_sample(24'h800000, 5, 1'b0);
        send_sample(24'h000001, 5, 1'b1);

        // Most negative coefficients
        load_filter(SAMPLE_LO, SAMPLE_LO, SAMPLE_LO, SAMPLE_LO, SAMPLE_LO);
        send_sample(24'h7FFFFF, 2, 1'b0);
        send_sample(24'h7FFFFF, 2, 1'b0);
        send_sample(24'h800000, 2, 1'b0);
        send_sample(24'h000000, 2, 1'b1);
        send_sample(24'hFFFFFF, 7, 1'b1);
        send_sample(24'h000000, 7, 1'b1);

        // Gain of one half: exact halves round toward plus infinity
        load_filter(64'sd524288, 0, 0, 0, 0);
        send_sample(24'h000001, 3, 1'b0);
        send_sample(24'hFFFFFF, 3, 1'b0);
        send_sample(24'h000003, 3, 1'b0);
        send_sample(24'hFFFFFD, 3, 1'b1);

        // Random part: one coefficient set per phase. Sender/sink pacing
        // moves from sender 34%/sink 52% idle, to the reverse, to none.
        cur_ch = CH_W'($urandom_range(MAX_CHANNELS - 1));
        for (int p = 0; p < 8; p++) begin
            case (p)
                0: load_filter(209715, 419430, 209715, -629146, 209715);     // gentle lowpass
                3: load_filter(52429, 0, -52429, -1992294, 996147);          // narrow resonance
                7: load_filter(longint'($signed(COEF_B0_RST)), 0, 0, 0, 0);  // back to unity
                default: begin
                    load_filter(rand_coef(p[0]), rand_coef(p[0]), rand_coef(p[0]),
                                rand_coef(p[0]), rand_coef(p[0]));
                end
            endcase
            if (p < 3) begin
                tx_idle_pct = 34;
                rx_idle_pct = 52;
            end else if (p < 6) begin
                tx_idle_pct = 52;
                rx_idle_pct = 34;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            // Long sink stall while the sender keeps pushing: backs up the block
            if (p == 1) rx_hold = 200;
            for (int i = 0; i < BEATS_PER_SET; i++) begin
                // Pause the sender mid-phase until every result is back
                if (p == 4 && i == BEATS_PER_SET / 2) quiesce();
                // Runs of samples on one channel, ending with last, then hop
                last = ($urandom_range(9) < 3);
                send_sample(rand_sample(), cur_ch, last);
                if (last) cur_ch = CH_W'($urandom_range(MAX_CHANNELS - 1));
            end
        end

        quiesce();
        $display("Filtered %0d samples on %0d channels across %0d coefficient sets",
                 beats_sent, MAX_CHANNELS, coef_sets + 1);
        $display("Saw %0d output beats, %0d of them clipped; %0d register writes",
                 sb.outputs_seen, sb.clipped_seen, cfg_writes);
        if (sb.mismatches == 0 && sb.owed_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
